// File: rtl/led_pkg.sv
`timescale 1ns / 1ps
// Shared types, constants and helpers for the line edge detector.
package led_pkg;

  localparam int COEF_W     = 16;
  localparam int NUM_COEF   = 5;
  localparam int HALF_TAPS  = NUM_COEF - 1;
  localparam int NUM_TAPS   = 2 * HALF_TAPS + 1;
  localparam int GROUP      = 3;
  localparam int NUM_GROUPS = NUM_TAPS / GROUP;
  localparam int ACC_W      = 32;
  localparam int BLUR_W     = 16;
  localparam int PIX_W      = 16;

  // A result for pixel i needs pixels up to i + LOOKAHEAD; that many zero
  // beats also close a line.
  localparam int LOOKAHEAD  = HALF_TAPS + 2;
  localparam int FLUSH_W    = $clog2(LOOKAHEAD + 1);

  localparam int OUT_DEPTH  = 8;
  localparam int PTR_W      = $clog2(OUT_DEPTH);
  localparam int CNT_W      = $clog2(OUT_DEPTH + 1);

  localparam int CFG_IDX_W  = 3;
  localparam logic [CFG_IDX_W-1:0] REG_COEF_CENTER = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_COEF_ONE    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_COEF_TWO    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_COEF_THREE  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_COEF_FOUR   = 3'd4;

  typedef logic [COEF_W-1:0] coef_t;
  typedef logic [NUM_COEF-1:0][COEF_W-1:0] coef_bank_t;

  // Entry 0 is the center weight, entry d the weight at distance d.
  localparam coef_bank_t COEF_RST = {16'd221, 16'd530, 16'd991, 16'd1442, 16'd1634};

  // First pixel index whose gradient may survive suppression.
  localparam logic [1:0] FIRST_KEPT = 2'd2;

  typedef struct packed {
    logic emit;
    logic keep;
    logic last;
  } mark_t;

  typedef struct packed {
    logic              last;
    logic [BLUR_W-1:0] value;
  } result_t;

  function automatic int tap_dist(input int k);
    return (k < HALF_TAPS) ? HALF_TAPS - k : k - HALF_TAPS;
  endfunction

endpackage

// File: rtl/led_tap_cell.sv
`timescale 1ns / 1ps
// One window cell: holds a pixel, hands it on, and registers its weighted tap.
module led_tap_cell #(
  parameter int PIXEL_BITS = 16
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      shift,
  input  logic [PIXEL_BITS-1:0]     pix_in,
  input  led_pkg::coef_t            coef,
  output logic [PIXEL_BITS-1:0]     tap,
  output logic [led_pkg::ACC_W-1:0] prod
);
  import led_pkg::*;

  localparam int PROD_W = PIXEL_BITS + COEF_W;

  logic [PROD_W-1:0] prod_full;

  // The window must start out as zero padding.
  always_ff @(posedge clk) begin
    if (rst) begin
      tap <= '0;
    end else if (shift) begin
      tap <= pix_in;
    end
  end

  assign prod_full = PROD_W'(coef) * PROD_W'(tap);

  always_ff @(posedge clk) begin
    prod <= ACC_W'(prod_full);
  end

endmodule

// File: rtl/led_grad_nms.sv
`timescale 1ns / 1ps
// Tap sum, blur window, central difference and non-maximum suppression.
module led_grad_nms #(
  parameter int SCALE_SHIFT = 13
) (
  input  logic                                             clk,
  input  logic                                             rst,
  input  logic                                             prod_valid,
  input  led_pkg::mark_t                                   prod_mark,
  input  logic [led_pkg::NUM_TAPS-1:0][led_pkg::ACC_W-1:0] prod,
  output logic                                             push,
  output led_pkg::result_t                                 push_data
);
  import led_pkg::*;

  logic [NUM_GROUPS-1:0][ACC_W-1:0] grp_sum;
  logic [NUM_GROUPS-1:0][ACC_W-1:0] psum;
  logic [ACC_W-1:0]                 total;
  logic [2:0][BLUR_W-1:0]           bw;
  logic [2:0][BLUR_W-1:0]           gw;
  logic                             v_sum;
  logic                             v_blur;
  logic                             v_grad;
  mark_t                            m_sum;
  mark_t                            m_blur;
  mark_t                            m_grad;
  logic signed [BLUR_W-1:0]         ga;
  logic signed [BLUR_W-1:0]         gb;
  logic signed [BLUR_W-1:0]         gc;
  logic                             is_peak;

  always_comb begin
    for (int j = 0; j < NUM_GROUPS; j++) begin
      grp_sum[j] = '0;
      for (int i = 0; i < GROUP; i++) begin
        grp_sum[j] = grp_sum[j] + prod[GROUP * j + i];
      end
    end
  end

  always_comb begin
    total = '0;
    for (int j = 0; j < NUM_GROUPS; j++) begin
      total = total + psum[j];
    end
  end

  always_ff @(posedge clk) begin
    psum  <= grp_sum;
    m_sum <= prod_mark;
    m_blur <= m_sum;
    m_grad <= m_blur;
    if (v_sum) begin
      bw <= {bw[1], bw[0], total[SCALE_SHIFT +: BLUR_W]};
    end
    // bw[0] is the blur one past the center, bw[2] one before it
    if (v_blur) begin
      gw <= {gw[1], gw[0], BLUR_W'(bw[0] - bw[2])};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v_sum  <= 1'b0;
      v_blur <= 1'b0;
      v_grad <= 1'b0;
    end else begin
      v_sum  <= prod_valid;
      v_blur <= v_sum;
      v_grad <= v_blur;
    end
  end

  assign ga = gw[2];
  assign gb = gw[1];
  assign gc = gw[0];

  // Plateaus count as extremes on either side.
  assign is_peak = ((gb >= ga) && (gb >= gc)) || ((gb <= ga) && (gb <= gc));

  assign push            = v_grad && m_grad.emit;
  assign push_data.last  = m_grad.last;
  assign push_data.value = (m_grad.keep && is_peak) ? gw[1] : '0;

endmodule

// File: rtl/led_out_fifo.sv
`timescale 1ns / 1ps
// Result queue between the gradient pipeline and the output stream.
module led_out_fifo (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  led_pkg::result_t push_data,
  output logic             out_valid,
  input  logic             out_ready,
  output led_pkg::result_t head
);
  import led_pkg::*;

  result_t          mem [OUT_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             pop;

  assign out_valid = (count != '0);
  assign pop       = out_valid && out_ready;
  assign head      = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      count <= count + CNT_W'(push) - CNT_W'(pop);
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    (push && !pop) |-> (count != CNT_W'(OUT_DEPTH)))
    else $error("result queue overflow");

  a_empty_ptrs: assert property (@(posedge clk) disable iff (rst)
    (count == '0) |-> (wr_ptr == rd_ptr))
    else $error("empty queue with unequal pointers");

  a_count_up: assert property (@(posedge clk) disable iff (rst)
    (push && !pop) |=> (count == $past(count) + 1'b1))
    else $error("queue count did not advance on push");

endmodule

// File: rtl/line_edge_detector_top.sv
`timescale 1ns / 1ps
// Path: the result for pixel i leaves once pixel i+6, or the matching tail zero
//   beat, has passed the tap, product, sum, blur and gradient registers and queue.
// Throughput: one pixel per cycle within a line while the result queue has room;
//   after each last pixel the cell row takes 6 zero beats (tready low).
// Reset: clears the pixel window, marks, counters and queue; coefficients
//   return to their defaults.
module line_edge_detector_top #(
  parameter int PIXEL_BITS  = 16,
  parameter int SCALE_SHIFT = 13
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_tvalid,
  output logic                              s_tready,
  input  logic [led_pkg::PIX_W-1:0]         s_tdata,   // [15:0] pixel
  input  logic                              s_tlast,   // last_pixel
  output logic                              m_tvalid,
  input  logic                              m_tready,
  output logic signed [led_pkg::BLUR_W-1:0] m_tdata,   // [15:0] edge_value
  output logic                              m_tlast,   // last_result
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [led_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [led_pkg::COEF_W-1:0]        cfg_data
);
  import led_pkg::*;

  coef_bank_t                          coef;
  logic [FLUSH_W-1:0]                  flush_cnt;
  logic [1:0]                          pos_cnt;
  mark_t [LOOKAHEAD-1:0]               mark_line;
  mark_t                               in_mark;
  logic [CNT_W-1:0]                    used;
  logic                                room;
  logic                                accept;
  logic                                bubble;
  logic                                step;
  logic [NUM_TAPS-1:0][PIXEL_BITS-1:0] taps;
  logic [NUM_TAPS-1:0][ACC_W-1:0]      prods;
  logic                                v_tap;
  logic                                v_prod;
  mark_t                               m_tap;
  mark_t                               m_prod;
  logic                                push;
  logic                                pop;
  result_t                             push_data;
  result_t                             head;

  // ---- configuration ----
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      coef <= COEF_RST;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_COEF_CENTER: coef[0] <= cfg_data;
        REG_COEF_ONE:    coef[1] <= cfg_data;
        REG_COEF_TWO:    coef[2] <= cfg_data;
        REG_COEF_THREE:  coef[3] <= cfg_data;
        REG_COEF_FOUR:   coef[4] <= cfg_data;
        default: ;
      endcase
    end
  end

  // ---- input control ----
  // used counts results reserved in the pipeline plus those in the queue.
  assign room     = (used < CNT_W'(OUT_DEPTH));
  assign s_tready = room && (flush_cnt == '0);
  assign accept   = s_tvalid && s_tready;
  assign bubble   = room && (flush_cnt != '0);
  assign step     = accept || bubble;

  always_comb begin
    in_mark = '0;
    if (accept) begin
      in_mark.emit = 1'b1;
      in_mark.keep = (pos_cnt == FIRST_KEPT) && !s_tlast;
      in_mark.last = s_tlast;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      flush_cnt <= '0;
      pos_cnt   <= '0;
    end else begin
      if (accept && s_tlast) begin
        flush_cnt <= FLUSH_W'(LOOKAHEAD);
      end else if (bubble) begin
        flush_cnt <= flush_cnt - 1'b1;
      end
      if (accept) begin
        if (s_tlast) begin
          pos_cnt <= '0;
        end else if (pos_cnt != FIRST_KEPT) begin
          pos_cnt <= pos_cnt + 1'b1;
        end
      end
    end
  end

  // Marks trail the pixels by LOOKAHEAD beats; the second to last pixel of a
  // line loses its keep when the last one arrives.
  always_ff @(posedge clk) begin
    if (rst) begin
      mark_line <= '0;
    end else if (step) begin
      mark_line[0]      <= in_mark;
      mark_line[1].emit <= mark_line[0].emit;
      mark_line[1].keep <= mark_line[0].keep && !(accept && s_tlast);
      mark_line[1].last <= mark_line[0].last;
      for (int k = 2; k < LOOKAHEAD; k++) begin
        mark_line[k] <= mark_line[k-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      used <= '0;
    end else begin
      used <= used + CNT_W'(step && mark_line[LOOKAHEAD-1].emit) - CNT_W'(pop);
    end
  end

  // ---- cell row ----
  for (genvar k = 0; k < NUM_TAPS; k++) begin : g_cell
    logic [PIXEL_BITS-1:0] feed;
    if (k == NUM_TAPS - 1) begin : g_head
      assign feed = accept ? s_tdata[PIXEL_BITS-1:0] : '0;
    end else begin : g_body
      assign feed = taps[k+1];
    end
    led_tap_cell #(
      .PIXEL_BITS(PIXEL_BITS)
    ) u_cell (
      .clk    (clk),
      .rst    (rst),
      .shift  (step),
      .pix_in (feed),
      .coef   (coef[tap_dist(k)]),
      .tap    (taps[k]),
      .prod   (prods[k])
    );
  end

  always_ff @(posedge clk) begin
    if (step) begin
      m_tap <= mark_line[LOOKAHEAD-1];
    end
    m_prod <= m_tap;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v_tap  <= 1'b0;
      v_prod <= 1'b0;
    end else begin
      v_tap  <= step;
      v_prod <= v_tap;
    end
  end

  led_grad_nms #(
    .SCALE_SHIFT(SCALE_SHIFT)
  ) u_grad (
    .clk        (clk),
    .rst        (rst),
    .prod_valid (v_prod),
    .prod_mark  (m_prod),
    .prod       (prods),
    .push       (push),
    .push_data  (push_data)
  );

  // ---- output ----
  led_out_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .head      (head)
  );

  assign pop     = m_tvalid && m_tready;
  assign m_tdata = head.value;
  assign m_tlast = head.last;

  a_credit_bound: assert property (@(posedge clk) disable iff (rst)
    used <= CNT_W'(OUT_DEPTH))
    else $error("result reservations exceed queue depth");

  a_tail_blocks_input: assert property (@(posedge clk) disable iff (rst)
    (flush_cnt != '0) |-> !s_tready)
    else $error("pixel accepted during line tail");

  a_tail_starts: assert property (@(posedge clk) disable iff (rst)
    (accept && s_tlast) |=> (flush_cnt == FLUSH_W'(LOOKAHEAD)))
    else $error("line tail not started after last pixel");

  a_push_reserved: assert property (@(posedge clk) disable iff (rst)
    push |-> (used != '0))
    else $error("result pushed without a reservation");

endmodule
